// ===== rtl/core/terq_pkg.sv =====
// Package for the timestamp event release queue: sizes, codes and the
// structures passed between controller and datapath. No dependencies.
package terq_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int SLOT_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int TREE_N     = 2 ** SLOT_W;
    // One register level per tree level.
    localparam int SRCH_LAT   = SLOT_W;
    localparam int CNT_W      = $clog2(SRCH_LAT + 1);

    localparam int TIME_W = 32;
    localparam int PAY_W  = 32;
    localparam int MS_W   = 16;
    localparam int LAG_W  = 16;

    localparam logic [LAG_W-1:0] LAG_RESET = 16'd1000;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // One node of the earliest-event search tree.
    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] tm;
        logic [SLOT_W-1:0] idx;
    } t_node;

    // Controller to datapath.
    typedef struct packed {
        logic arr;     // store the accepted arrival
        logic clamp;   // first target step: sum clamped to the horizon
        logic lag;     // second target step: lag limit
        logic rd;      // take the earliest due event out of the pool
        logic ld_rel;  // load the release record into the output register
        logic ld_fin;  // load the final record into the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic found;     // the search root holds an event due by the target
        logic out_free;  // the output register can take a record this cycle
    } t_sts;

endpackage

// ===== rtl/core/terq_ctrl.sv =====
// Controller of the timestamp event release queue: sequences target
// computation, search, release and final record. Depends on terq_pkg.
module terq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_op,
    input  terq_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output terq_pkg::t_cmd o_cmd
);
    import terq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LAG  = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_acc;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Next state, wait counter and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_op == OP_TICK) begin
                        o_cmd.clamp = 1'b1;
                        n_state     = ST_LAG;
                    end else begin
                        o_cmd.arr = 1'b1;
                    end
                end
            end
            ST_LAG: begin
                o_cmd.lag = 1'b1;
                n_cnt     = '0;
                n_state   = ST_SRCH;
            end
            ST_SRCH: begin
                if (r_cnt == CNT_W'(SRCH_LAT)) begin
                    n_state = i_sts.found ? ST_RD : ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_rel = 1'b1;
                    n_cnt        = '0;
                    n_state      = ST_SRCH;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_fin = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/terq_dp.sv =====
// Datapath of the timestamp event release queue: event pool, payload
// memory, search tree, time registers and output register. Depends on terq_pkg.
module terq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [terq_pkg::TIME_W-1:0]    i_event_time,
    input  logic                           i_horizon_only,
    input  logic [terq_pkg::PAY_W-1:0]     i_event_payload,
    input  logic [terq_pkg::MS_W-1:0]      i_tick_ms,
    input  logic                           i_cfg_wen,
    input  logic [terq_pkg::LAG_W-1:0]     i_cfg_wdata,
    input  terq_pkg::t_cmd                 i_cmd,
    output terq_pkg::t_sts                 o_sts,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic                           o_kind,
    output logic [terq_pkg::PAY_W-1:0]     o_released_payload,
    output logic [terq_pkg::TIME_W-1:0]    o_released_time,
    output logic [terq_pkg::TIME_W-1:0]    o_advance_ms,
    output logic                           o_last
);
    import terq_pkg::*;

    logic [POOL_DEPTH-1:0] r_slot_vld;
    logic [TIME_W-1:0]     r_slot_tm [POOL_DEPTH];
    logic [PAY_W-1:0]      r_pay_mem [POOL_DEPTH];
    logic [PAY_W-1:0]      r_pay_rd;
    logic [TIME_W-1:0]     r_hzn;
    logic [TIME_W-1:0]     r_cur;
    logic [TIME_W-1:0]     r_target;
    logic [LAG_W-1:0]      r_lag;
    logic [TIME_W-1:0]     r_pick_tm;

    logic                  r_o_vld;
    logic                  r_o_kind;
    logic [PAY_W-1:0]      r_o_pay;
    logic [TIME_W-1:0]     r_o_tm;
    logic [TIME_W-1:0]     r_o_adv;
    logic                  r_o_last;

    t_node                 leaf   [TREE_N];
    t_node                 r_node [1:TREE_N-1];
    t_node                 w_root;

    logic                  w_free_any;
    logic [SLOT_W-1:0]     w_free_idx;
    logic [TIME_W:0]       w_sum;
    logic [TIME_W:0]       w_reach;
    logic                  w_out_free;

    // Lowest free slot for an arriving event.
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (!r_slot_vld[i]) begin
                w_free_any = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    // Leaves of the search tree, read straight from the slot registers.
    for (genvar i = 0; i < TREE_N; i++) begin : g_leaf
        if (i < POOL_DEPTH) begin : g_used
            assign leaf[i] = '{vld: r_slot_vld[i], tm: r_slot_tm[i], idx: SLOT_W'(i)};
        end else begin : g_pad
            assign leaf[i] = '0;
        end
    end

    // Registered tree: the right child (higher slots) wins on equal times.
    for (genvar n = 1; n < TREE_N; n++) begin : g_tree
        t_node w_lo, w_hi;
        if (2 * n >= TREE_N) begin : g_from_leaf
            assign w_lo = leaf[2 * n - TREE_N];
            assign w_hi = leaf[2 * n + 1 - TREE_N];
        end else begin : g_from_node
            assign w_lo = r_node[2 * n];
            assign w_hi = r_node[2 * n + 1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_node[n] <= '0;
            end else if (w_hi.vld && (!w_lo.vld || w_hi.tm <= w_lo.tm)) begin
                r_node[n] <= w_hi;
            end else begin
                r_node[n] <= w_lo;
            end
        end
    end

    assign w_root = r_node[1];

    // Target arithmetic, both sums kept one bit wider so they cannot wrap.
    assign w_sum   = {1'b0, r_cur} + {{(TIME_W + 1 - MS_W){1'b0}}, i_tick_ms};
    assign w_reach = {1'b0, r_target} + {{(TIME_W + 1 - LAG_W){1'b0}}, r_lag};

    assign w_out_free   = !r_o_vld || i_m_tready;
    assign o_sts.found  = w_root.vld && (w_root.tm <= r_target);
    assign o_sts.out_free = w_out_free;

    // Control registers: pool occupancy, horizon, current time and lag limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_hzn      <= '0;
            r_cur      <= '0;
            r_lag      <= LAG_RESET;
        end else begin
            if (i_cfg_wen) begin
                r_lag <= i_cfg_wdata;
            end
            if (i_cmd.arr) begin
                if (i_event_time > r_hzn) begin
                    r_hzn <= i_event_time;
                end
                if (!i_horizon_only && w_free_any) begin
                    r_slot_vld[w_free_idx] <= 1'b1;
                end
            end
            if (i_cmd.rd) begin
                r_slot_vld[w_root.idx] <= 1'b0;
            end
            if (i_cmd.ld_rel) begin
                r_cur <= r_pick_tm;
            end
            if (i_cmd.ld_fin) begin
                r_cur <= r_target;
            end
        end
    end

    // Slot times, payload memory and the target and pick registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.arr && !i_horizon_only && w_free_any) begin
            r_slot_tm[w_free_idx] <= i_event_time;
            r_pay_mem[w_free_idx] <= i_event_payload;
        end
        if (i_cmd.rd) begin
            r_pay_rd  <= r_pay_mem[w_root.idx];
            r_pick_tm <= w_root.tm;
        end
        if (i_cmd.clamp) begin
            r_target <= (w_sum > {1'b0, r_hzn}) ? r_hzn : w_sum[TIME_W-1:0];
        end
        if (i_cmd.lag && (w_reach < {1'b0, r_hzn})) begin
            r_target <= r_hzn - {{(TIME_W - LAG_W + 1){1'b0}}, r_lag[LAG_W-1:1]};
        end
    end

    // Output register: holds a record until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.ld_rel || i_cmd.ld_fin) begin
            r_o_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_rel) begin
            r_o_kind <= KIND_EVENT;
            r_o_pay  <= r_pay_rd;
            r_o_tm   <= r_pick_tm;
            r_o_adv  <= r_pick_tm - r_cur;
            r_o_last <= 1'b0;
        end else if (i_cmd.ld_fin) begin
            r_o_kind <= KIND_FINAL;
            r_o_pay  <= '0;
            r_o_tm   <= r_target;
            r_o_adv  <= r_target - r_cur;
            r_o_last <= 1'b1;
        end
    end

    assign o_m_tvalid         = r_o_vld;
    assign o_kind             = r_o_kind;
    assign o_released_payload = r_o_pay;
    assign o_released_time    = r_o_tm;
    assign o_advance_ms       = r_o_adv;
    assign o_last             = r_o_last;

    // A release only takes an event that is due by the target.
    a_rd_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (w_root.vld && (w_root.tm <= r_target)))
        else $error("release of an event beyond the target");

    // The released slot is free on the next cycle.
    a_rd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |=> !r_slot_vld[$past(w_root.idx)])
        else $error("released slot still marked valid");

    // Once worked out, the target never passes the horizon.
    a_tgt_hzn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.lag) |-> (r_target <= r_hzn))
        else $error("target beyond horizon");

    // The final record leaves the current time at the target.
    a_fin_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_fin |=> (r_cur == $past(r_target)))
        else $error("current time not at target after final record");

endmodule

// ===== rtl/core/timestamp_event_release_queue_top.sv =====
// Top level of the timestamp event release queue: stream ports and the
// max_lag register port. Depends on terq_pkg, terq_ctrl and terq_dp.
//
//   Channel   Direction  Handshake              Content
//   s (in)    slave      i_s_tvalid/o_s_tready  arrival or tick item
//   m (out)   master     o_m_tvalid/i_m_tready  release or final record
//   cfg       in         i_cfg_wen              max_lag, written at once
//
// An arrival is taken in the idle state. A tick sets its target in two steps
// (clamp to the horizon, then the lag limit); then, for each due event, it waits
// in the search state for the tree, takes the event out and loads its release
// record, and when none is due it loads the final record. The search waits on the
// registered search tree over the slots, whose root must settle after a slot is freed.
// Reset is synchronous and active low; it empties the pool and clears both times.
// A stalled output holds the controller in place; arrivals are taken only
// while no tick is in progress.
module timestamp_event_release_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // event_time, event_payload, tick_ms
    input  logic [1:0]  i_s_tuser,   // op, horizon_only
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // released_payload, released_time, advance_ms
    output logic        o_m_tuser,   // kind
    output logic        o_m_tlast,
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata
);
    import terq_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [PAY_W-1:0]  w_pay;
    logic [TIME_W-1:0] w_tm;
    logic [TIME_W-1:0] w_adv;

    terq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser[0]),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    terq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_event_time       (i_s_tdata[31:0]),
        .i_horizon_only     (i_s_tuser[1]),
        .i_event_payload    (i_s_tdata[63:32]),
        .i_tick_ms          (i_s_tdata[79:64]),
        .i_cfg_wen          (i_cfg_wen),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_m_tready         (i_m_tready),
        .o_m_tvalid         (o_m_tvalid),
        .o_kind             (o_m_tuser),
        .o_released_payload (w_pay),
        .o_released_time    (w_tm),
        .o_advance_ms       (w_adv),
        .o_last             (o_m_tlast)
    );

    assign o_m_tdata = {w_adv, w_tm, w_pay};

endmodule

// ===== verif/terq_checker.sv =====
// Checker for the timestamp event release queue: watches the item channels
// and the max_lag port, predicts every release record and compares.
// Depends on terq_pkg for sizes and codes.
module terq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,   // event_time, event_payload, tick_ms
    input  logic [1:0]  i_s_tuser,   // op, horizon_only
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,   // released_payload, released_time, advance_ms
    input  logic        i_m_tuser,   // kind
    input  logic        i_m_tlast,
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_records
);
    timeunit 1ns;
    timeprecision 1ps;
    import terq_pkg::*;

    // One release record as it should leave the block.
    typedef struct {
        logic                     kind;
        logic [PAY_W-1:0]         payload;
        logic [TIME_W-1:0]        when;
        logic signed [TIME_W-1:0] step;
        logic                     fin;
    } t_release;

    // Shadow copy of the pool, the two times and the lag register.
    logic              slot_busy [POOL_DEPTH];
    logic [TIME_W-1:0] slot_tm   [POOL_DEPTH];
    logic [PAY_W-1:0]  slot_pay  [POOL_DEPTH];
    logic [TIME_W-1:0] horizon;
    logic [TIME_W-1:0] now_ms;
    logic [LAG_W-1:0]  lag_limit;

    t_release due_records[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // An arrival raises the horizon and, unless horizon-only, takes the lowest free slot if any.
    task automatic admit_event(input logic [TIME_W-1:0] etime, input logic honly,
                               input logic [PAY_W-1:0] pay);
        bit placed;
        placed = 1'b0;
        if (etime > horizon) begin
            horizon = etime;
        end
        if (!honly) begin
            for (int i = 0; i < POOL_DEPTH; i++) begin
                if (!placed && !slot_busy[i]) begin
                    slot_busy[i] = 1'b1;
                    slot_tm[i]   = etime;
                    slot_pay[i]  = pay;
                    placed       = 1'b1;
                end
            end
        end
    endtask

    // A tick settles its target, then releases due events earliest first;
    // on equal times the later slot in the scan wins, so the highest slot goes first.
    task automatic advance_clock(input logic [MS_W-1:0] ms);
        logic [TIME_W+1:0] span;
        logic [TIME_W-1:0] target;
        logic [TIME_W-1:0] best;
        int                pick;
        t_release          rec;
        span = {2'b00, now_ms} + ms;
        if (span > {2'b00, horizon}) begin
            span = {2'b00, horizon};
        end
        if (span + lag_limit < {2'b00, horizon}) begin
            span = {2'b00, horizon} - (lag_limit >> 1);
        end
        target = span[TIME_W-1:0];
        pick = 0;
        while (pick >= 0) begin
            pick = -1;
            best = target;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                if (slot_busy[i] && slot_tm[i] <= best) begin
                    pick = i;
                    best = slot_tm[i];
                end
            end
            if (pick >= 0) begin
                rec.kind    = KIND_EVENT;
                rec.payload = slot_pay[pick];
                rec.when    = best;
                rec.step    = best - now_ms;
                rec.fin     = 1'b0;
                due_records.push_back(rec);
                now_ms          = best;
                slot_busy[pick] = 1'b0;
            end
        end
        rec.kind    = KIND_FINAL;
        rec.payload = '0;
        rec.when    = target;
        rec.step    = target - now_ms;
        rec.fin     = 1'b1;
        due_records.push_back(rec);
        now_ms = target;
    endtask

    // Compare one accepted record with the oldest expectation.
    task automatic check_record();
        t_release exp_rec;
        if (due_records.size() == 0) begin
            report_mismatch($sformatf("record with nothing pending, data %h",
                                      i_m_tdata));
        end else begin
            exp_rec = due_records.pop_front();
            o_records++;
            if (i_m_tuser !== exp_rec.kind) begin
                report_mismatch($sformatf("kind %b, expected %b", i_m_tuser,
                                          exp_rec.kind));
            end
            if (i_m_tdata[31:0] !== exp_rec.payload) begin
                report_mismatch($sformatf("payload %h, expected %h", i_m_tdata[31:0],
                                          exp_rec.payload));
            end
            if (i_m_tdata[63:32] !== exp_rec.when) begin
                report_mismatch($sformatf("time %h, expected %h", i_m_tdata[63:32],
                                          exp_rec.when));
            end
            if (i_m_tdata[95:64] !== exp_rec.step) begin
                report_mismatch($sformatf("advance %0d, expected %0d",
                                          $signed(i_m_tdata[95:64]), exp_rec.step));
            end
            if (i_m_tlast !== exp_rec.fin) begin
                report_mismatch($sformatf("last %b, expected %b", i_m_tlast,
                                          exp_rec.fin));
            end
        end
    endtask

    // Sample every channel at the clock edge; records are checked before
    // the new item is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_DEPTH; i++) begin
                slot_busy[i] = 1'b0;
            end
            horizon   = '0;
            now_ms    = '0;
            lag_limit = LAG_RESET;
            due_records.delete();
        end else begin
            if (i_cfg_wen) begin
                lag_limit = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                check_record();
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_TICK) begin
                    advance_clock(i_s_tdata[79:64]);
                end else begin
                    admit_event(i_s_tdata[31:0], i_s_tuser[1], i_s_tdata[63:32]);
                end
            end
        end
        o_pending = due_records.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the timestamp event release queue: clock, reset,
// item stimulus, max_lag writes and the verdict. Depends on terq_pkg,
// timestamp_event_release_queue_top and terq_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import terq_pkg::*;

    localparam int DRAIN_CYCLES = 16;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [79:0] i_s_tdata   = '0;   // event_time, event_payload, tick_ms
    logic [1:0]  i_s_tuser   = '0;   // op, horizon_only
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_wen   = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [95:0] o_m_tdata;          // released_payload, released_time, advance_ms
    logic        o_m_tuser;          // kind
    logic        o_m_tlast;

    int fail_count;
    int pending;
    int records;

    // Set for the closing stretch, where neither side idles.
    bit calm = 1'b0;
    int items_sent = 0;
    int ticks_sent = 0;
    int lag_writes = 0;
    int rx_stall   = 0;

    timestamp_event_release_queue_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    terq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_records    (records)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: ready most of the time, with stall bursts outside the calm stretch.
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall   <= rx_stall - 1;
            i_m_tready <= (rx_stall == 1);
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            rx_stall   <= $urandom_range(1, 12);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Hand one item to the block, after an optional idle burst, and wait
    // until it is taken. Valid stays high for a following item.
    task automatic offer_item(input logic op, input logic [31:0] etime,
                              input logic honly, input logic [31:0] pay,
                              input logic [15:0] ms);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ms, pay, etime};
        i_s_tuser  <= {honly, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        if (op == OP_TICK) begin
            ticks_sent++;
        end
    endtask

    // Hold off until every expected record has come and the block is idle.
    task automatic settle_queue();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write max_lag; only called with the block idle.
    task automatic write_lag(input logic [15:0] lag);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= lag;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        lag_writes++;
    endtask

    // Stimulus and verdict.
    initial begin
        logic [15:0] lag_plan [5];
        logic [31:0] base;
        logic [31:0] etime;
        logic [15:0] ms;
        int          dice;

        lag_plan[0] = 16'd0;
        lag_plan[1] = 16'hFFFF;
        lag_plan[2] = 16'($urandom_range(1, 4000));
        lag_plan[3] = LAG_RESET;
        lag_plan[4] = 16'($urandom_range(0, 65535));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a tick on the empty pool, a horizon-only arrival and a
        // tick that jumps forward by the lag rule.
        offer_item(OP_TICK, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 16'd0);
        offer_item(OP_ARRIVAL, 32'd5000, 1'b1, 32'h0, 16'hFFFF);
        offer_item(OP_TICK, 32'h0, 1'b0, 32'h0, 16'd0);

        // Fill the pool: equal times, late events, time zero, payload extremes.
        offer_item(OP_ARRIVAL, 32'd4600, 1'b0, 32'h00000000, 16'd0);
        offer_item(OP_ARRIVAL, 32'd4600, 1'b0, 32'hFFFFFFFF, 16'd0);
        offer_item(OP_ARRIVAL, 32'd100, 1'b0, 32'hA5A5A5A5, 16'd0);
        offer_item(OP_ARRIVAL, 32'd0, 1'b0, 32'h5A5A5A5A, 16'd0);
        for (int i = 0; i < 12; i++) begin
            offer_item(OP_ARRIVAL, 32'd4700 + 32'(i) * 600, 1'b0, $urandom,
                       16'($urandom));
        end

        // The pool is full now: this arrival is dropped.
        offer_item(OP_ARRIVAL, 32'd4650, 1'b0, 32'hDEADBEEF, 16'd0);

        // Largest tick, clamped to the horizon, releases the whole pool.
        offer_item(OP_TICK, $urandom, 1'b0, $urandom, 16'hFFFF);
        offer_item(OP_TICK, $urandom, 1'b1, $urandom, 16'd0);

        // Random phases, one max_lag setting each; the last one without idling.
        base = 32'd12000;
        for (int ph = 0; ph < 5; ph++) begin
            settle_queue();
            write_lag(lag_plan[ph]);
            calm = (ph == 4);
            for (int n = 0; n < 52; n++) begin
                dice = $urandom_range(0, 99);
                ms   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
                if (dice < 2) begin
                    // Noise: a timestamp from anywhere in the range.
                    etime = $urandom;
                    if (etime > base) begin
                        base = etime;
                    end
                    offer_item(OP_ARRIVAL, etime, 1'($urandom_range(0, 1)), $urandom, ms);
                end else if (dice < 8) begin
                    offer_item(OP_ARRIVAL, base + $urandom_range(0, 2000), 1'b1,
                               $urandom, ms);
                end else if (dice < 60) begin
                    // Mostly near the present, some of them already late.
                    etime = base + $urandom_range(0, 3000) - 32'd500;
                    if (etime > base) begin
                        base = etime;
                    end
                    offer_item(OP_ARRIVAL, etime, 1'b0, $urandom, ms);
                end else begin
                    offer_item(OP_TICK, $urandom, 1'($urandom_range(0, 1)), $urandom, ms);
                end
            end
        end

        // Closing: the latest possible timestamp, first held back by the
        // widest lag, then reached once the lag is zero.
        settle_queue();
        write_lag(16'hFFFF);
        offer_item(OP_ARRIVAL, 32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 16'd0);
        offer_item(OP_TICK, 32'h0, 1'b0, 32'h0, 16'd0);
        settle_queue();
        write_lag(16'd0);
        offer_item(OP_TICK, 32'h0, 1'b0, 32'h0, 16'd0);
        settle_queue();

        $display("Covered %0d items (%0d ticks) over %0d max_lag settings;",
                 items_sent, ticks_sent, lag_writes + 1);
        $display("%0d release records were checked against the prediction.", records);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/terq_pkg.sv
rtl/core/terq_ctrl.sv
rtl/core/terq_dp.sv
rtl/core/timestamp_event_release_queue_top.sv
verif/terq_checker.sv
verif/tb_top.sv
